FILE: src/benv_pkg.sv
// Package for the breakpoint envelope interpolator.
// It holds the item types, the request and mode codes, the table sizes and the state type.
// It has no dependencies.
`default_nettype none
package benv_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int NORM_MIN_RANGE = 65;
	localparam int FRAC_W = 16;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_NORM  = 2'd2,
		REQ_NOP   = 2'd3
	} req_kind_t;

	localparam logic [1:0] MODE_STEP = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_SMOOTH = 2'd2;
	localparam logic [1:0] MODE_SMOOTH_ALT = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [31:0]        time_pos;
		logic signed [23:0] point_val;
	} benv_req_t;

	typedef struct packed {
		logic signed [23:0] env_value;
		logic               status;
		logic [4:0]         point_total;
	} benv_rsp_t;

	typedef struct packed {
		logic [31:0]        time_pos;
		logic signed [23:0] value;
	} benv_entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CHK,
		ST_Q_RD,
		ST_Q_CHK,
		ST_Q_DIV,
		ST_Q_SQ,
		ST_Q_SM,
		ST_Q_BLEND,
		ST_N_RD,
		ST_N_CHK,
		ST_N2_RD,
		ST_N2_ST,
		ST_N2_DIV,
		ST_DONE
	} benv_state_t;

endpackage
`default_nettype wire

FILE: src/benv_div.sv
// Serial restoring divider giving floor(num * 65536 / den) for num <= den.
// One quotient bit per cycle; the result is held until the next start.
// Depends on benv_pkg.
`default_nettype none
module benv_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [16:0]      quot
);
	import benv_pkg::*;

	logic [32:0]       rem_q;
	logic [31:0]       den_q;
	logic [FRAC_W-1:0] quo_q;
	logic [3:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              eq_q;
	logic [32:0]       shifted;
	logic              take;

	assign shifted = {rem_q[31:0], 1'b0};
	assign take = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'(FRAC_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			eq_q <= num == den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? shifted - {1'b0, den_q} : shifted;
			quo_q <= {quo_q[FRAC_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = eq_q ? 17'h10000 : {1'b0, quo_q};

endmodule
`default_nettype wire

FILE: src/breakpoint_envelope_interpolator_unit.sv
// Breakpoint envelope interpolator: a sorted table of up to 16 points in one synchronous memory.
// An add moves each later point up one slot and then writes the new one; a full table only sets the status.
// A query scans the points in order; linear and smoothstep modes then divide and blend.
// Normalise finds the minimum and maximum and rescales every point if their range exceeds 65.
// One item at a time, the next accepted as its result appears; a 1R1W memory and one divider.
// Reset clears the point count and sets linear mode; the table contents are left undefined.
`default_nettype none
module breakpoint_envelope_interpolator_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire benv_pkg::benv_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output benv_pkg::benv_rsp_t      rsp,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_data
);
	import benv_pkg::*;

	benv_entry_t mem [MAX_POINTS];
	benv_entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;
	benv_entry_t      wr_data;

	benv_state_t state_q, state_d;
	benv_req_t   req_q;
	logic [1:0]  mode_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_dec;
	logic [31:0] prev_t_q, t0_q, keep_t_q;
	logic signed [23:0] prev_v_q, v0_q, va_q, vb_q, lo_q, hi_q;
	logic signed [23:0] res_q;
	logic        stat_q;
	logic [16:0] t_q, t2_q;
	logic [17:0] k_q;
	logic        rsp_valid_q;
	benv_rsp_t   rsp_q;

	logic        accept;
	logic        is_last;
	logic        found;
	logic        need_div;
	logic        rsp_load;
	logic        div_start;
	logic [31:0] div_num, div_den;
	logic        div_done;
	logic [16:0] div_quot;
	logic signed [24:0] range;
	logic signed [23:0] lo_d, hi_d;
	logic signed [24:0] range_d;
	logic signed [24:0] offset;
	logic signed [24:0] diff;
	logic signed [42:0] prod;
	logic [33:0] sq;
	logic [34:0] sm;
	logic signed [26:0] blended;

	assign accept = req_valid && !req_stall;
	assign req_stall = state_q != ST_IDLE;
	assign idx_dec = idx_q - CNT_W'(1);
	assign is_last = idx_q == cnt_q - CNT_W'(1);
	assign found = idx_q != '0 && req_q.time_pos >= prev_t_q && req_q.time_pos <= rd_q.time_pos;
	assign need_div = mode_q != MODE_STEP && prev_t_q != rd_q.time_pos;
	assign rsp_load = !rsp_valid_q || !rsp_stall;
	assign range = {hi_q[23], hi_q} - {lo_q[23], lo_q};
	assign lo_d = (idx_q == '0 || rd_q.value < lo_q) ? rd_q.value : lo_q;
	assign hi_d = (idx_q == '0 || rd_q.value > hi_q) ? rd_q.value : hi_q;
	assign range_d = {hi_d[23], hi_d} - {lo_d[23], lo_d};
	assign offset = {rd_q.value[23], rd_q.value} - {lo_q[23], lo_q};
	assign diff = {vb_q[23], vb_q} - {va_q[23], va_q};
	assign prod = diff * $signed({1'b0, t_q});
	assign blended = prod[42:16] + 27'(va_q);
	assign sq = t_q * t_q;
	assign sm = t2_q * k_q;

	benv_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = idx_q[IDX_W-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		wr_data = {req_q.time_pos, req_q.point_val};
		div_start = 1'b0;
		div_num = req_q.time_pos - prev_t_q;
		div_den = rd_q.time_pos - prev_t_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.req_type)
						REQ_ADD:   state_d = cnt_q >= CNT_W'(MAX_POINTS) ? ST_DONE : ST_ADD_RD;
						REQ_QUERY: state_d = cnt_q == '0 ? ST_DONE : ST_Q_RD;
						REQ_NORM:  state_d = cnt_q == '0 ? ST_DONE : ST_N_RD;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_ADD_RD: begin
				rd_addr = idx_dec[IDX_W-1:0];
				if (idx_q == '0) begin
					wr_en = 1'b1;
					state_d = ST_DONE;
				end else begin
					state_d = ST_ADD_CHK;
				end
			end
			ST_ADD_CHK: begin
				wr_en = 1'b1;
				if (rd_q.time_pos > req_q.time_pos) begin
					wr_data = rd_q;
					state_d = ST_ADD_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_Q_RD: state_d = ST_Q_CHK;
			ST_Q_CHK: begin
				if (found) begin
					div_start = need_div;
					state_d = need_div ? ST_Q_DIV : ST_DONE;
				end else if (is_last) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_Q_RD;
				end
			end
			ST_Q_DIV: begin
				if (div_done) begin
					state_d = mode_q == MODE_LINEAR ? ST_Q_BLEND : ST_Q_SQ;
				end
			end
			ST_Q_SQ:    state_d = ST_Q_SM;
			ST_Q_SM:    state_d = ST_Q_BLEND;
			ST_Q_BLEND: state_d = ST_DONE;
			ST_N_RD:    state_d = ST_N_CHK;
			ST_N_CHK: begin
				if (!is_last) begin
					state_d = ST_N_RD;
				end else if (idx_q == '0 || range_d <= 25'sd65) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_N2_RD;
				end
			end
			ST_N2_RD: state_d = ST_N2_ST;
			ST_N2_ST: begin
				div_start = 1'b1;
				div_num = 32'(unsigned'(offset));
				div_den = 32'(unsigned'(range));
				state_d = ST_N2_DIV;
			end
			ST_N2_DIV: begin
				if (div_done) begin
					wr_en = 1'b1;
					wr_data = {keep_t_q, 7'd0, div_quot};
					state_d = is_last ? ST_DONE : ST_N2_RD;
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_LINEAR;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_data;
			end
			if ((state_q == ST_ADD_RD && idx_q == '0) ||
					(state_q == ST_ADD_CHK && rd_q.time_pos <= req_q.time_pos)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ST_DONE && rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				req_q <= req;
				idx_q <= '0;
				res_q <= '0;
				stat_q <= 1'b0;
				if (accept && req.req_type == REQ_ADD) begin
					idx_q <= cnt_q;
					stat_q <= cnt_q >= CNT_W'(MAX_POINTS);
				end
			end
			ST_ADD_CHK: begin
				if (rd_q.time_pos > req_q.time_pos) begin
					idx_q <= idx_dec;
				end
			end
			ST_Q_CHK: begin
				prev_t_q <= rd_q.time_pos;
				prev_v_q <= rd_q.value;
				va_q <= prev_v_q;
				vb_q <= rd_q.value;
				idx_q <= idx_q + CNT_W'(1);
				if (idx_q == '0) begin
					t0_q <= rd_q.time_pos;
					v0_q <= rd_q.value;
				end
				if (found) begin
					res_q <= prev_v_q;
				end else if (is_last) begin
					res_q <= (idx_q != '0 && req_q.time_pos < t0_q) ? v0_q : rd_q.value;
				end
			end
			ST_Q_DIV: t_q <= div_quot;
			ST_Q_SQ: begin
				t2_q <= sq[32:16];
				k_q <= 18'd196608 - {t_q, 1'b0};
			end
			ST_Q_SM: t_q <= sm[32:16];
			ST_Q_BLEND: res_q <= blended[23:0];
			ST_N_CHK: begin
				lo_q <= lo_d;
				hi_q <= hi_d;
				idx_q <= is_last ? '0 : idx_q + CNT_W'(1);
			end
			ST_N2_ST: keep_t_q <= rd_q.time_pos;
			ST_N2_DIV: begin
				if (div_done) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			ST_DONE: begin
				if (rsp_load) begin
					rsp_q <= {res_q, stat_q, cnt_q};
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_POINTS))
		else $error("point count above table size");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted item did not start work");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> rsp.point_total == 5'(MAX_POINTS) && rsp.env_value == '0)
		else $error("full status with bad fields");

	a_div_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_Q_DIV || state_q == ST_N2_DIV)
		else $error("divider finished outside a waiting state");

endmodule
`default_nettype wire
